// ===== design/npsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npsd_pkg
// Shared widths, opcodes and the sequencer state type of the 3D
// nearest-point search block.
// ----------------------------------------------------------------------------
package npsd_pkg;

   localparam int COORD_W     = 24;            // signed Q12.12 coordinate
   localparam int REF_W       = 3 * COORD_W;   // packed x, y, z entry
   localparam int DIFF_W      = COORD_W + 1;   // magnitude of a difference
   localparam int SQ_W        = 2 * COORD_W + 1; // square, at most 2^48
   localparam int SUM_W       = SQ_W + 1;      // sum of three squares
   localparam int ROOT_W      = SUM_W / 2;     // floor root of the sum
   localparam int REM_W       = ROOT_W + 2;    // partial remainder
   localparam int ROOT_STEP_W = $clog2(ROOT_W);
   localparam int INDEX_W     = 10;
   localparam int DIST_W      = 26;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ROOT,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== design/nearest_point_search_3d.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_point_search_3d
// Brute-force nearest neighbor over a store of 3D Q12.12 reference points.
//
// Request channel (req_*): one beat per item. op=load appends the point to
// the store (restart=1 empties the store first and clears the drop flag);
// a load beyond MAX_REFS is dropped and flags overflowed on later queries.
// op=query searches every stored point for the smallest squared distance.
// Response channel (rsp_*): one beat per query, none per load: found, index
// of the nearest point (lowest on ties), floor root of the minimum squared
// distance (Q14.12) and the overflow flag.
// Flow: a load leaves the block ready for the next item. A query scans every
// stored point, and the next item is taken once its result is in the response
// register. The path is one RAM read per point, a 4-stage distance pipeline
// and a bit-serial square root; the single RAM read port sets the scan length.
// An empty store skips the scan and the root and goes straight to the answer.
// One item is worked at a time. The response register holds a beat while
// rsp_ready is low; a following load is taken meanwhile, and a finished
// query waits for the register to free.
// Reset empties the store and clears the drop flag; no clearing pass.
// ----------------------------------------------------------------------------
module nearest_point_search_3d #(
   parameter int MAX_REFS = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_op,
   input  wire logic                                 req_restart,
   input  wire logic signed [npsd_pkg::COORD_W-1:0]  req_coord_x,
   input  wire logic signed [npsd_pkg::COORD_W-1:0]  req_coord_y,
   input  wire logic signed [npsd_pkg::COORD_W-1:0]  req_coord_z,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_found,
   output logic             [npsd_pkg::INDEX_W-1:0]  rsp_nearest_index,
   output logic             [npsd_pkg::DIST_W-1:0]   rsp_min_distance,
   output logic                                      rsp_overflowed
);

   localparam int ADDR_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
   localparam int CNT_W  = $clog2(MAX_REFS + 1);
   localparam int CW     = npsd_pkg::COORD_W;
   localparam int DW     = npsd_pkg::DIFF_W;

   function automatic logic [DW-1:0] abs_diff(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
      logic [DW-1:0] d;
      d = {a[CW-1], a} - {b[CW-1], b};
      return d[DW-1] ? (~d + 1'b1) : d;
   endfunction

   npsd_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              drop_ff,  drop_in;
   logic [CNT_W-1:0]  scan_ff,  scan_in;

   logic [CW-1:0]     q_x_ff, q_y_ff, q_z_ff;

   logic                       rd_valid_ff;
   logic [ADDR_W-1:0]          rd_idx_ff;
   logic                       d_valid_ff;
   logic [ADDR_W-1:0]          d_idx_ff;
   logic [DW-1:0]              mag_x_ff, mag_y_ff, mag_z_ff;
   logic                       s_valid_ff;
   logic [ADDR_W-1:0]          s_idx_ff;
   logic [npsd_pkg::SQ_W-1:0]  sq_x_ff, sq_y_ff, sq_z_ff;
   logic                       m_valid_ff;
   logic [ADDR_W-1:0]          m_idx_ff;
   logic [npsd_pkg::SUM_W-1:0] sum_ff;

   logic                       best_valid_ff;
   logic [npsd_pkg::SUM_W-1:0] best_d_ff;
   logic [ADDR_W-1:0]          best_idx_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_found_ff;
   logic [npsd_pkg::INDEX_W-1:0] rsp_index_ff;
   logic [npsd_pkg::DIST_W-1:0]  rsp_dist_ff;
   logic                        rsp_over_ff;

   logic [2*DW-1:0]            prod_x, prod_y, prod_z;
   logic [npsd_pkg::SUM_W-1:0] sum_in;
   logic [npsd_pkg::INDEX_W+ADDR_W-1:0] idx_wide;

   logic                       accept, load_acc, query_acc;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic                       rd_en;
   logic [npsd_pkg::REF_W-1:0] rd_data;
   logic                       scan_done;
   logic                       sqrt_start, sqrt_done;
   logic [npsd_pkg::ROOT_W-1:0] sqrt_root;
   logic                       out_load;
   logic                       update;

   assign accept    = req_valid && req_ready;
   assign load_acc  = accept && (req_op == npsd_pkg::OP_LOAD);
   assign query_acc = accept && (req_op == npsd_pkg::OP_QUERY);

   // store write: restart always lands at index zero, otherwise append while there is room
   assign wr_en   = load_acc && (req_restart || (count_ff < CNT_W'(MAX_REFS)));
   assign wr_addr = req_restart ? '0 : count_ff[ADDR_W-1:0];

   assign scan_done = (scan_ff == count_ff) && !rd_valid_ff && !d_valid_ff &&
                      !s_valid_ff && !m_valid_ff;

   npsd_ram #(
      .WIDTH (npsd_pkg::REF_W),
      .DEPTH (MAX_REFS)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_coord_x, req_coord_y, req_coord_z}),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   npsd_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (best_d_ff),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npsd_pkg::ST_IDLE: begin
            if (query_acc) begin
               state_in = (count_ff == '0) ? npsd_pkg::ST_DONE : npsd_pkg::ST_SCAN;
            end
         end
         npsd_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = npsd_pkg::ST_ROOT;
            end
         end
         npsd_pkg::ST_ROOT: begin
            if (sqrt_done) begin
               state_in = npsd_pkg::ST_DONE;
            end
         end
         npsd_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = npsd_pkg::ST_IDLE;
            end
         end
         default: state_in = npsd_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready  = 1'b0;
      rd_en      = 1'b0;
      sqrt_start = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         npsd_pkg::ST_IDLE: req_ready = 1'b1;
         npsd_pkg::ST_SCAN: begin
            rd_en      = (scan_ff < count_ff);
            sqrt_start = scan_done;
         end
         npsd_pkg::ST_ROOT: ;
         npsd_pkg::ST_DONE: out_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // count and drop flag
   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      if (load_acc) begin
         if (req_restart) begin
            count_in = CNT_W'(1);
            drop_in  = 1'b0;
         end else if (count_ff < CNT_W'(MAX_REFS)) begin
            count_in = count_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (query_acc) begin
         scan_in = '0;
      end else if (rd_en) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   assign prod_x = mag_x_ff * mag_x_ff;
   assign prod_y = mag_y_ff * mag_y_ff;
   assign prod_z = mag_z_ff * mag_z_ff;
   assign sum_in = {1'b0, sq_x_ff} + {1'b0, sq_y_ff} + {1'b0, sq_z_ff};
   assign update = m_valid_ff && (!best_valid_ff || (sum_ff < best_d_ff));
   assign idx_wide = {{npsd_pkg::INDEX_W{1'b0}}, best_idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= npsd_pkg::ST_IDLE;
         count_ff      <= '0;
         drop_ff       <= 1'b0;
         rd_valid_ff   <= 1'b0;
         d_valid_ff    <= 1'b0;
         s_valid_ff    <= 1'b0;
         m_valid_ff    <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         drop_ff     <= drop_in;
         rd_valid_ff <= rd_en;
         d_valid_ff  <= rd_valid_ff;
         s_valid_ff  <= d_valid_ff;
         m_valid_ff  <= s_valid_ff;
         if (query_acc) begin
            best_valid_ff <= 1'b0;
         end else if (update) begin
            best_valid_ff <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      scan_ff <= scan_in;
      if (query_acc) begin
         q_x_ff <= req_coord_x;
         q_y_ff <= req_coord_y;
         q_z_ff <= req_coord_z;
      end

      // distance pipeline: read, difference, square, sum, compare
      rd_idx_ff <= scan_ff[ADDR_W-1:0];
      d_idx_ff  <= rd_idx_ff;
      mag_x_ff  <= abs_diff(q_x_ff, rd_data[3*CW-1 -: CW]);
      mag_y_ff  <= abs_diff(q_y_ff, rd_data[2*CW-1 -: CW]);
      mag_z_ff  <= abs_diff(q_z_ff, rd_data[CW-1:0]);
      s_idx_ff  <= d_idx_ff;
      sq_x_ff   <= prod_x[npsd_pkg::SQ_W-1:0];
      sq_y_ff   <= prod_y[npsd_pkg::SQ_W-1:0];
      sq_z_ff   <= prod_z[npsd_pkg::SQ_W-1:0];
      m_idx_ff  <= s_idx_ff;
      sum_ff    <= sum_in;
      if (update) begin
         best_d_ff   <= sum_ff;
         best_idx_ff <= m_idx_ff;
      end

      if (out_load) begin
         rsp_found_ff <= best_valid_ff;
         rsp_index_ff <= best_valid_ff ? idx_wide[npsd_pkg::INDEX_W-1:0] : '0;
         rsp_dist_ff  <= best_valid_ff ? npsd_pkg::DIST_W'(sqrt_root) : '0;
         rsp_over_ff  <= drop_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_nearest_index = rsp_index_ff;
   assign rsp_min_distance  = rsp_dist_ff;
   assign rsp_overflowed    = rsp_over_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_REFS))
      else $error("reference count beyond capacity");
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == npsd_pkg::ST_IDLE)
      else $error("store written during a query");
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      load_acc |=> state_ff == npsd_pkg::ST_IDLE && count_ff != '0)
      else $error("load did not complete in one cycle");
   a_root_after_scan: assert property (@(posedge clock) disable iff (reset)
      sqrt_start |-> best_valid_ff && !m_valid_ff)
      else $error("square root started before the scan drained");
   a_count_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == npsd_pkg::ST_SCAN |=> $stable(count_ff))
      else $error("reference count changed during a scan");
`endif

endmodule
`default_nettype wire

// ===== design/npsd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npsd_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module npsd_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== design/npsd_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npsd_sqrt
// Iterative floor square root, one result bit per cycle (restoring,
// two radicand bits per step).
// ----------------------------------------------------------------------------
module npsd_sqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [npsd_pkg::SUM_W-1:0]   operand,
   output logic                              done,
   output logic      [npsd_pkg::ROOT_W-1:0]  root
);

   localparam int CAT_W = npsd_pkg::REM_W + 2;

   logic                               busy_ff,  busy_in;
   logic                               done_ff,  done_in;
   logic [npsd_pkg::ROOT_STEP_W-1:0]   step_ff,  step_in;
   logic [npsd_pkg::SUM_W-1:0]         rad_ff,   rad_in;
   logic [npsd_pkg::REM_W-1:0]         rem_ff,   rem_in;
   logic [npsd_pkg::ROOT_W-1:0]        root_ff,  root_in;

   logic [CAT_W-1:0] cat;
   logic [CAT_W-1:0] trial;
   logic [CAT_W-1:0] diff;
   logic             ge;

   assign cat   = {rem_ff, rad_ff[npsd_pkg::SUM_W-1 -: 2]};
   assign trial = {{(CAT_W - npsd_pkg::ROOT_W - 2){1'b0}}, root_ff, 2'b01};
   assign diff  = cat - trial;
   assign ge    = (cat >= trial);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = npsd_pkg::ROOT_STEP_W'(npsd_pkg::ROOT_W - 1);
         rad_in  = operand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = ge ? diff[npsd_pkg::REM_W-1:0] : cat[npsd_pkg::REM_W-1:0];
         root_in = {root_ff[npsd_pkg::ROOT_W-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("square root started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("square root done without a finished run");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= npsd_pkg::ROOT_STEP_W'(npsd_pkg::ROOT_W - 1))
      else $error("square root step count out of range");
`endif

endmodule
`default_nettype wire
